// ===== rtl/mas_pkg.sv =====
// Shared constants for the square matrix add / subtract / multiply block.
`timescale 1ns / 1ps

package mas_pkg;

    // Largest supported matrix dimension and derived storage sizes
    localparam int unsigned MAX_DIM     = 8;
    localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned AREA_W      = $clog2(STORE_DEPTH + 1);
    localparam int unsigned CNT_W       = AREA_W + 1;

    // Field and register widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DIM_W    = 4;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION_MODE = 1'd1;

    // Reset values of the registers
    localparam logic [DIM_W-1:0]  SIZE_RESET = 4'd2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_MUL;

endpackage

// ===== rtl/matrix_add_sub_multiply.sv =====
// Square matrix add / subtract / multiply block: two element stores and a MAC sequencer.
`timescale 1ns / 1ps

// Load the first n-by-n matrix and then the second, one element per cycle in
// row-major order; the transaction that delivers the last element of the second
// matrix starts the computation and the block emits n*n results in row-major
// order, with m_last_of_matrix set on the final one. Each matrix sits in its own
// simple dual-port synchronous store, read one element per cycle, so a product
// result takes n reads through the single multiplier, then the store read, term
// and accumulator registers drain and the result moves to the output register once
// it is free; a sum or difference result takes one read. No input is taken
// while results are being computed; the last result may wait in the output register
// while the next pair of matrices loads. Writing matrix_size restarts the load;
// values 0 and above 8 act as 1 and 8. Mode 3 returns zeros. Arithmetic wraps to
// 32 bits.
module matrix_add_sub_multiply (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mas_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mas_pkg::CFG_W-1:0]         cfg_wr_data,
    // element input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mas_pkg::DATA_W-1:0] s_element_value,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mas_pkg::DATA_W-1:0] m_result_value,
    output logic                              m_last_of_matrix
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int unsigned AW = mas_pkg::ADDR_W;
    localparam int unsigned DW = mas_pkg::DATA_W;
    localparam int unsigned XW = mas_pkg::IDX_W;
    localparam int unsigned NW = mas_pkg::DIM_W;
    localparam int unsigned CW = mas_pkg::CNT_W;

    // Element stores
    logic [DW-1:0] first_mem  [mas_pkg::STORE_DEPTH];
    logic [DW-1:0] second_mem [mas_pkg::STORE_DEPTH];

    logic [1:0]                  state_reg, state_next;
    logic [NW-1:0]               size_reg, size_next;
    logic [mas_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [CW-1:0]               load_cnt_reg, load_cnt_next;
    logic [XW-1:0]               row_reg, row_next;
    logic [XW-1:0]               col_reg, col_next;
    logic [XW-1:0]               k_reg, k_next;
    logic [AW-1:0]               row_base_reg, row_base_next;
    logic [AW-1:0]               elem_idx_reg, elem_idx_next;
    logic [AW-1:0]               a_ptr_reg, a_ptr_next;
    logic [AW-1:0]               b_ptr_reg, b_ptr_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        term_valid_reg, term_valid_next;
    logic [DW-1:0]               a_rd_reg, b_rd_reg;
    logic [DW-1:0]               term_reg, term_next;
    logic [DW-1:0]               acc_reg, acc_next;
    logic                        m_valid_reg, m_valid_next;
    logic [DW-1:0]               m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    logic [NW-1:0]               dim;
    logic [NW-1:0]               dim_m1;
    logic [mas_pkg::AREA_W-1:0]  area;
    logic [CW-1:0]               two_area;
    logic [CW-1:0]               load_pos;
    logic [CW-1:0]               second_off;
    logic                        load_first;
    logic                        in_fire;
    logic                        is_mul;
    logic [NW-1:0]               k_max;
    logic                        k_last;
    logic                        col_last;
    logic                        row_last;
    logic                        out_free;
    logic [AW-1:0]               wr_addr;

    // Clamp the size register to a usable dimension
    always_comb begin
        if (size_reg == '0) begin
            dim = NW'(1);
        end else if (size_reg > NW'(mas_pkg::MAX_DIM)) begin
            dim = NW'(mas_pkg::MAX_DIM);
        end else begin
            dim = size_reg;
        end
    end

    assign dim_m1   = dim - NW'(1);
    assign area     = mas_pkg::AREA_W'(dim * dim);
    assign two_area = {area, 1'b0};
    assign load_pos = (load_cnt_reg >= two_area) ? '0 : load_cnt_reg;
    assign second_off = load_pos - CW'(area);
    assign load_first = (load_pos < CW'(area));
    assign wr_addr    = load_first ? load_pos[AW-1:0] : second_off[AW-1:0];

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign is_mul   = (mode_reg == mas_pkg::MODE_MUL);
    assign k_max    = is_mul ? dim : NW'(1);
    assign k_last   = (NW'(k_reg) == k_max - NW'(1));
    assign col_last = (NW'(col_reg) == dim_m1);
    assign row_last = (NW'(row_reg) == dim_m1);
    assign out_free = !m_valid_reg || m_ready;

    // Store writes during load
    always_ff @(posedge aclk) begin
        if (in_fire && load_first) begin
            first_mem[wr_addr] <= s_element_value;
        end
        if (in_fire && !load_first) begin
            second_mem[wr_addr] <= s_element_value;
        end
    end

    // Store reads, one element of each matrix per cycle
    always_ff @(posedge aclk) begin
        a_rd_reg <= first_mem[a_ptr_reg];
        b_rd_reg <= second_mem[b_ptr_reg];
    end

    // Form one term: sum, difference or product of the fetched pair, or zero in mode 3
    always_comb begin
        case (mode_reg)
            mas_pkg::MODE_ADD: term_next = a_rd_reg + b_rd_reg;
            mas_pkg::MODE_SUB: term_next = a_rd_reg - b_rd_reg;
            mas_pkg::MODE_MUL: term_next = a_rd_reg * b_rd_reg;
            default:           term_next = '0;
        endcase
    end

    // Sequencer: load, issue reads, drain pipeline, hand off result
    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        mode_next       = mode_reg;
        load_cnt_next   = load_cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        row_base_next   = row_base_reg;
        elem_idx_next   = elem_idx_reg;
        a_ptr_next      = a_ptr_reg;
        b_ptr_next      = b_ptr_reg;
        rd_valid_next   = 1'b0;
        term_valid_next = rd_valid_reg;
        acc_next        = term_valid_reg ? acc_reg + term_reg : acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (load_pos == two_area - CW'(1)) begin
                        load_cnt_next = '0;
                        state_next    = ST_READ;
                        row_next      = '0;
                        col_next      = '0;
                        k_next        = '0;
                        row_base_next = '0;
                        elem_idx_next = '0;
                        a_ptr_next    = '0;
                        b_ptr_next    = '0;
                        acc_next      = '0;
                    end else begin
                        load_cnt_next = load_pos + CW'(1);
                    end
                end
            end
            ST_READ: begin
                rd_valid_next = 1'b1;
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next     = k_reg + XW'(1);
                    a_ptr_next = a_ptr_reg + AW'(1);
                    b_ptr_next = b_ptr_reg + AW'(dim);
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !term_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    m_last_next  = col_last && row_last;
                    acc_next     = '0;
                    if (col_last && row_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next    = ST_READ;
                        elem_idx_next = elem_idx_reg + AW'(1);
                        if (col_last) begin
                            col_next      = '0;
                            row_next      = row_reg + XW'(1);
                            row_base_next = row_base_reg + AW'(dim);
                        end else begin
                            col_next = col_reg + XW'(1);
                        end
                        a_ptr_next = is_mul ? row_base_next : elem_idx_next;
                        b_ptr_next = is_mul ? AW'(col_next) : elem_idx_next;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // Configuration writes; a size write drops any partial load
        if (cfg_wr_en) begin
            case (cfg_addr)
                mas_pkg::REG_MATRIX_SIZE: begin
                    size_next     = cfg_wr_data[NW-1:0];
                    load_cnt_next = '0;
                end
                mas_pkg::REG_OPERATION_MODE: begin
                    mode_next = cfg_wr_data[mas_pkg::MODE_W-1:0];
                end
                default: begin
                    size_next = size_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            size_reg       <= mas_pkg::SIZE_RESET;
            mode_reg       <= mas_pkg::MODE_RESET;
            load_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            term_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            mode_reg       <= mode_next;
            load_cnt_reg   <= load_cnt_next;
            rd_valid_reg   <= rd_valid_next;
            term_valid_reg <= term_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        k_reg        <= k_next;
        row_base_reg <= row_base_next;
        elem_idx_reg <= elem_idx_next;
        a_ptr_reg    <= a_ptr_next;
        b_ptr_reg    <= b_ptr_next;
        term_reg     <= term_next;
        acc_reg      <= acc_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_value   = $signed(m_data_reg);
    assign m_last_of_matrix = m_last_reg;

    // Pipeline carries data only while a result is being computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg || term_valid_reg) |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("MAC pipeline active outside compute");

    // Issued store addresses stay inside the loaded matrices
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |->
            (AW'(0) + a_ptr_reg < area && AW'(0) + b_ptr_reg < area))
        else $error("store read address beyond loaded matrix");

    // The final result returns the block to loading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && col_last && row_last) |=>
            (state_reg == ST_LOAD && m_valid_reg && m_last_reg))
        else $error("final result did not end the emission");

    // Load position stays below two matrices while loading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (load_cnt_reg < two_area))
        else $error("load count out of range");

endmodule

// ===== tb/matrix_result_checker.sv =====
// Result checker for the square matrix add / subtract / multiply block.
`timescale 1ns / 1ps

module matrix_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mas_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mas_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [mas_pkg::DATA_W-1:0] s_element_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [mas_pkg::DATA_W-1:0] m_result_value,
    input  logic                              m_last_of_matrix,
    output int                                mismatch_count,
    output int                                results_pending
);

    typedef struct {
        logic signed [mas_pkg::DATA_W-1:0] value;
        logic                              last;
    } matrix_element_t;

    // Predicted result elements, oldest first
    matrix_element_t awaited_elements[$];

    // Shadow copy of the operand stores and registers
    logic [mas_pkg::DATA_W-1:0] first_matrix  [mas_pkg::STORE_DEPTH];
    logic [mas_pkg::DATA_W-1:0] second_matrix [mas_pkg::STORE_DEPTH];
    int unsigned                elements_loaded;
    logic [mas_pkg::DIM_W-1:0]  size_reg;
    logic [mas_pkg::MODE_W-1:0] mode_reg;

    // Clamp the size register to 1..MAX_DIM
    function automatic int unsigned active_dim();
        if (size_reg == 0)
            return 1;
        if (size_reg > mas_pkg::MAX_DIM)
            return mas_pkg::MAX_DIM;
        return 32'(size_reg);
    endfunction

    function automatic logic [mas_pkg::DATA_W-1:0] result_element(int unsigned n,
                                                                  int unsigned i,
                                                                  int unsigned j);
        logic [mas_pkg::DATA_W-1:0] acc;
        acc = '0;
        case (mode_reg)
            mas_pkg::MODE_ADD: acc = first_matrix[i*n+j] + second_matrix[i*n+j];
            mas_pkg::MODE_SUB: acc = first_matrix[i*n+j] - second_matrix[i*n+j];
            mas_pkg::MODE_MUL: begin
                // Keep the low 32 bits of every product and of the running sum
                for (int unsigned k = 0; k < n; k++)
                    acc = acc + first_matrix[i*n+k] * second_matrix[k*n+j];
            end
            default: acc = '0;
        endcase
        return acc;
    endfunction

    // Store one element; on the last element of the pair, queue the whole result matrix
    task automatic absorb_element(input logic [mas_pkg::DATA_W-1:0] v);
        int unsigned     n;
        int unsigned     area;
        matrix_element_t elem;
        n    = active_dim();
        area = n * n;
        if (elements_loaded >= 2 * area)
            elements_loaded = 0;
        if (elements_loaded < area)
            first_matrix[elements_loaded] = v;
        else
            second_matrix[elements_loaded - area] = v;
        elements_loaded++;
        if (elements_loaded < 2 * area)
            return;
        elements_loaded = 0;
        for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = 0; j < n; j++) begin
                elem.value = result_element(n, i, j);
                elem.last  = (i == n - 1) && (j == n - 1);
                awaited_elements.push_back(elem);
            end
        end
    endtask

    always @(posedge aclk) begin
        matrix_element_t oldest;
        if (!aresetn) begin
            mismatch_count  = 0;
            elements_loaded = 0;
            size_reg        = mas_pkg::SIZE_RESET;
            mode_reg        = mas_pkg::MODE_RESET;
            awaited_elements.delete();
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    mas_pkg::REG_MATRIX_SIZE: begin
                        size_reg        = cfg_wr_data[mas_pkg::DIM_W-1:0];
                        elements_loaded = 0;
                    end
                    mas_pkg::REG_OPERATION_MODE: begin
                        mode_reg = cfg_wr_data[mas_pkg::MODE_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                absorb_element(s_element_value);

            // Compare each result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                if (awaited_elements.size() == 0) begin
                    $error("unexpected result transaction: result_value %0d last_of_matrix %0b",
                           m_result_value, m_last_of_matrix);
                    mismatch_count++;
                end else begin
                    oldest = awaited_elements.pop_front();
                    if (m_result_value !== oldest.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               oldest.value, m_result_value);
                        mismatch_count++;
                    end
                    if (m_last_of_matrix !== oldest.last) begin
                        $error("last_of_matrix: expected %0b, actual %0b",
                               oldest.last, m_last_of_matrix);
                        mismatch_count++;
                    end
                end
            end
        end
        results_pending = awaited_elements.size();
    end

endmodule

// ===== tb/matrix_add_sub_multiply_tb.sv =====
// Stimulus and verdict for the square matrix add / subtract / multiply block.
`timescale 1ns / 1ps

module matrix_add_sub_multiply_tb;

    localparam int unsigned CW = mas_pkg::CFG_W;
    localparam int unsigned DW = mas_pkg::DATA_W;
    localparam logic [mas_pkg::MODE_W-1:0] MODE_UNDEFINED = 2'd3;
    localparam logic signed [DW-1:0] ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int ITEMS_PER_PHASE  = 6;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [mas_pkg::CFG_IDX_W-1:0]     cfg_addr;
    logic [CW-1:0]                     cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [DW-1:0]              s_element_value;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [DW-1:0]              m_result_value;
    logic                              m_last_of_matrix;
    int                                mismatch_count;
    int                                results_pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int unsigned size_now      = mas_pkg::SIZE_RESET;

    matrix_add_sub_multiply DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_last_of_matrix (m_last_of_matrix)
    );

    matrix_result_checker checker_inst (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_last_of_matrix (m_last_of_matrix),
        .mismatch_count   (mismatch_count),
        .results_pending  (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned pair_dim();
        if (size_now == 0)
            return 1;
        if (size_now > mas_pkg::MAX_DIM)
            return mas_pkg::MAX_DIM;
        return size_now;
    endfunction

    // Mostly full-range values, with small values and extremes mixed in
    function automatic logic signed [DW-1:0] pick_element();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return -1;
                    default: return 0;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one element and hold it until accepted; called at a falling edge
    task automatic send_element(input logic signed [DW-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_element_value = v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_results();
        s_valid = 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [mas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CW-1:0] data);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = data;
        if (idx == mas_pkg::REG_MATRIX_SIZE)
            size_now = 32'(data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_random_pair();
        repeat (2 * pair_dim() * pair_dim())
            send_element(pick_element());
    endtask

    initial begin
        int unsigned n;
        int unsigned count;
        int          sent;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = mas_pkg::REG_MATRIX_SIZE;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_element_value = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings (2x2 multiply) with extreme operands
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(-1);
        send_element(0);
        send_element(ELEM_MAX);
        send_element(1);
        send_element(ELEM_MIN);
        send_element(-1);

        // 1x1 add and subtract across the wrap boundary
        write_reg(mas_pkg::REG_MATRIX_SIZE, CW'(1));
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_ADD));
        send_element(ELEM_MAX);
        send_element(1);
        send_element(ELEM_MIN);
        send_element(-1);
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_SUB));
        send_element(ELEM_MIN);
        send_element(1);

        // Undefined mode returns zeros
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(MODE_UNDEFINED));
        send_element(ELEM_MAX);
        send_element(ELEM_MAX);

        // Size zero acts as one
        write_reg(mas_pkg::REG_MATRIX_SIZE, CW'(0));
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_MUL));
        send_element(ELEM_MIN);
        send_element(-1);

        // Size write drops a half-loaded pair
        send_element(12345);
        write_reg(mas_pkg::REG_MATRIX_SIZE, CW'(1));
        send_element(7);
        send_element(-3);

        // Mode write in the middle of a load leaves the load intact
        send_element(100);
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_SUB));
        send_element(-28);

        // Random pairs under three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct <= 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct <= 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(mas_pkg::REG_MATRIX_SIZE, CW'($urandom_range(0, 3)));
                    write_reg(mas_pkg::REG_OPERATION_MODE, CW'($urandom_range(0, 3)));
                end
                n     = pair_dim();
                count = 2 * n * n;
                // Occasionally abandon a pair partway and restart the load
                if ($urandom_range(0, 7) == 0) begin
                    count = $urandom_range(1, 2 * n * n - 1);
                    repeat (count) send_element(pick_element());
                    write_reg(mas_pkg::REG_MATRIX_SIZE, CW'(size_now));
                end else begin
                    repeat (count) send_element(pick_element());
                end
                sent += count;
            end
            // Pause the sender until all results are out
            drain_results();
        end

        // Hold off the result side while pairs keep coming, so the input stalls
        write_reg(mas_pkg::REG_MATRIX_SIZE, CW'(1));
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_ADD));
        hold_requests <= hold_requests + 1;
        repeat (3) send_random_pair();

        // A size above the maximum acts as the largest size
        write_reg(mas_pkg::REG_MATRIX_SIZE, CW'($urandom_range(mas_pkg::MAX_DIM + 1, 15)));
        write_reg(mas_pkg::REG_OPERATION_MODE, CW'(mas_pkg::MODE_MUL));
        send_random_pair();

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mas_pkg.sv
rtl/matrix_add_sub_multiply.sv
tb/matrix_result_checker.sv
tb/matrix_add_sub_multiply_tb.sv
